// ===== sv/xte_pkg.sv =====
// Shared types, character codes and run-expansion functions for the XML text escaper.
package xte_pkg;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_APOS,
    KIND_QUOT,
    KIND_NUM
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam int QueueDepth = 2;
  localparam int RunMax     = 6;
  localparam int IdxW       = $clog2(RunMax);

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChO     = 8'h6F;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChQ     = 8'h71;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;

  function automatic logic [IdxW-1:0] run_len(kind_t kind);
    logic [IdxW-1:0] len;
    unique case (kind)
      KIND_PASS: len = IdxW'(1);
      KIND_AMP:  len = IdxW'(5);
      KIND_LT:   len = IdxW'(4);
      KIND_GT:   len = IdxW'(4);
      KIND_APOS: len = IdxW'(6);
      KIND_QUOT: len = IdxW'(6);
      KIND_NUM:  len = IdxW'(5);
      default:   len = IdxW'(1);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] run_char(item_t it, logic [IdxW-1:0] idx);
    logic [4:0]            val;
    logic [1:0]            tens;
    logic [4:0]            ones;
    logic [RunMax-1:0][7:0] txt;
    logic [7:0]            ch;
    val = it.raw[4:0];
    if (val >= 5'd30) begin
      tens = 2'd3;
    end else if (val >= 5'd20) begin
      tens = 2'd2;
    end else if (val >= 5'd10) begin
      tens = 2'd1;
    end else begin
      tens = 2'd0;
    end
    ones = val - 5'(tens) * 5'd10;
    txt = '0;
    txt[0] = ChAmp;
    unique case (it.kind)
      KIND_PASS: begin
        txt[0] = it.raw;
      end
      KIND_AMP: begin
        txt[1] = ChA; txt[2] = ChM; txt[3] = ChP; txt[4] = ChSemi;
      end
      KIND_LT: begin
        txt[1] = ChL; txt[2] = ChT; txt[3] = ChSemi;
      end
      KIND_GT: begin
        txt[1] = ChG; txt[2] = ChT; txt[3] = ChSemi;
      end
      KIND_APOS: begin
        txt[1] = ChA; txt[2] = ChP; txt[3] = ChO; txt[4] = ChS; txt[5] = ChSemi;
      end
      KIND_QUOT: begin
        txt[1] = ChQ; txt[2] = ChU; txt[3] = ChO; txt[4] = ChT; txt[5] = ChSemi;
      end
      KIND_NUM: begin
        txt[1] = ChHash;
        txt[2] = ChZero + {6'd0, tens};
        txt[3] = ChZero + {3'd0, ones};
        txt[4] = ChSemi;
      end
      default: begin
        txt[0] = it.raw;
      end
    endcase
    ch = (idx < IdxW'(RunMax)) ? txt[idx] : it.raw;
    return ch;
  endfunction

endpackage

// ===== sv/xte_if.sv =====
// Stream interfaces for the text byte input and the escaped byte output.
interface xte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== sv/xml_text_escaper_top.sv =====
// XML text escaper: one text byte in, its escaped run of one to six bytes out, last byte marked.
// The block sends one output byte per clock cycle when the output side is ready and the queue
// holds an item. A byte that passes through is sent as it is; the others become "&lt;",
// "&gt;", "&amp;", numeric entities "&#DD;", "&apos;" or "&quot;". The back stage walks
// the run with a byte counter through its single output register. A two-entry queue sits
// between the classifying front stage and the back stage. The item whose run is being sent
// stays at the head of the queue until its last byte, so one further input byte is taken while
// a run is being sent and two while a finished byte waits on the output; the input then stalls.
// Nothing is kept between bytes.
module xml_text_escaper_top #(
  parameter int QueueDepth = xte_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  xte_in_if.sink    in_ch,
  xte_out_if.source out_ch
);

  xte_pkg::q_stat_t q_stat;
  xte_pkg::item_t   push_item;
  xte_pkg::item_t   head_item;
  logic             push;
  logic             pop;

  xte_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  xte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  xte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // Inside a run the next byte is ready right after each transfer.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.run_last) |=> out_ch.valid)
    else $error("escaped run broken by a gap");

  // A semicolon only ever closes an entity.
  a_semi_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.run_last) |-> (out_ch.out_byte != xte_pkg::ChSemi))
    else $error("semicolon inside an escaped run");

  // An item leaves the queue only on the transfer into the output register of its last byte.
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_ch.valid && out_ch.run_last))
    else $error("queue popped without a final byte");

endmodule

// ===== sv/xte_front.sv =====
// Front stage: accepts text bytes and classifies each one into an escape kind.
module xte_front (
  xte_in_if.sink          in_ch,
  input  xte_pkg::q_stat_t q_stat,
  output logic            push,
  output xte_pkg::item_t  push_item
);

  xte_pkg::kind_t kind;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    unique case (in_ch.in_byte)
      xte_pkg::ChAmp:  kind = xte_pkg::KIND_AMP;
      xte_pkg::ChLt:   kind = xte_pkg::KIND_LT;
      xte_pkg::ChGt:   kind = xte_pkg::KIND_GT;
      xte_pkg::ChApos: kind = xte_pkg::KIND_APOS;
      xte_pkg::ChQuot: kind = xte_pkg::KIND_QUOT;
      default: begin
        // Bytes below space other than tab, line feed and carriage return become numeric entities.
        if (in_ch.in_byte < xte_pkg::ChSpace && in_ch.in_byte != xte_pkg::ChTab &&
            in_ch.in_byte != xte_pkg::ChLf && in_ch.in_byte != xte_pkg::ChCr) begin
          kind = xte_pkg::KIND_NUM;
        end else begin
          kind = xte_pkg::KIND_PASS;
        end
      end
    endcase
  end

  assign push_item.kind = kind;
  assign push_item.raw  = in_ch.in_byte;

endmodule

// ===== sv/xte_queue.sv =====
// Short FIFO of classified items between the front and back stages.
module xte_queue #(
  parameter int Depth = xte_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xte_pkg::item_t   push_item,
  input  logic             pop,
  output xte_pkg::item_t   head_item,
  output xte_pkg::q_stat_t q_stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  xte_pkg::item_t  mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CntW'(Depth));
  assign head_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/xte_back.sv =====
// Back stage: expands the head item into its run of bytes through an output register.
module xte_back (
  input  logic             clk,
  input  logic             rst_n,
  input  xte_pkg::item_t   head_item,
  input  xte_pkg::q_stat_t q_stat,
  output logic             pop,
  xte_out_if.source        out_ch
);

  logic [xte_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r;
  logic                     run_last_r;
  logic                     load;
  logic                     take;
  logic                     last;

  assign load = !out_valid_r || out_ch.ready;
  assign take = load && !q_stat.empty;
  assign last = (idx_r == xte_pkg::run_len(head_item.kind) - 1'b1);
  assign pop  = take && last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      idx_nxt       = last ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r <= xte_pkg::run_char(head_item, idx_r);
      run_last_r <= last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = run_last_r;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the XML text escaper: random stream handshakes and a run predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int LimitCycles = 200000;
  localparam int DrainCycles = 30;
  localparam int PhaseItems  = 175;
  localparam int StallAt     = 80;
  localparam int StallCycles = 150;
  localparam int CalmFirst   = 230;
  localparam int CalmLast    = 300;

  localparam logic [7:0] MarkupChars [5] = '{xte_pkg::ChAmp, xte_pkg::ChLt, xte_pkg::ChGt,
                                             xte_pkg::ChApos, xte_pkg::ChQuot};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  xte_in_if  in_ch ();
  xte_out_if out_ch ();

  xml_text_escaper_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0] text_queue [$];
  esc_byte_t  escaped_queue [$];
  int         errors = 0;
  int         queued_count = 0;
  int         sent_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         stall_done = 1'b0;
  bit         in_fire = 1'b0;
  wire        calm = (sent_count >= CalmFirst) && (sent_count < CalmLast);

  always #1 clk = ~clk;

  // Appends the escaped form of one text byte to the expected output stream.
  function automatic void escape_run(logic [7:0] b);
    logic [7:0] txt [$];
    case (b)
      xte_pkg::ChAmp:  txt = '{xte_pkg::ChAmp, xte_pkg::ChA, xte_pkg::ChM, xte_pkg::ChP,
                               xte_pkg::ChSemi};
      xte_pkg::ChLt:   txt = '{xte_pkg::ChAmp, xte_pkg::ChL, xte_pkg::ChT, xte_pkg::ChSemi};
      xte_pkg::ChGt:   txt = '{xte_pkg::ChAmp, xte_pkg::ChG, xte_pkg::ChT, xte_pkg::ChSemi};
      xte_pkg::ChApos: txt = '{xte_pkg::ChAmp, xte_pkg::ChA, xte_pkg::ChP, xte_pkg::ChO,
                               xte_pkg::ChS, xte_pkg::ChSemi};
      xte_pkg::ChQuot: txt = '{xte_pkg::ChAmp, xte_pkg::ChQ, xte_pkg::ChU, xte_pkg::ChO,
                               xte_pkg::ChT, xte_pkg::ChSemi};
      default: begin
        if (b < xte_pkg::ChSpace && b != xte_pkg::ChTab && b != xte_pkg::ChLf &&
            b != xte_pkg::ChCr) begin
          txt = '{xte_pkg::ChAmp, xte_pkg::ChHash, 8'(xte_pkg::ChZero + b / 8'd10),
                  8'(xte_pkg::ChZero + b % 8'd10), xte_pkg::ChSemi};
        end else begin
          txt = '{b};
        end
      end
    endcase
    for (int i = 0; i < txt.size(); i++) begin
      escaped_queue.push_back(esc_byte_t'{txt[i], 1'(i == txt.size() - 1)});
    end
  endfunction

  // Mix of plain text, markup characters, control bytes and arbitrary bytes.
  function automatic logic [7:0] pick_text_byte();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) begin
      return 8'($urandom_range(8'h7E, 8'h20));
    end else if (sel < 6) begin
      return MarkupChars[$urandom_range(4)];
    end else if (sel < 8) begin
      return 8'($urandom_range(8'h1F));
    end else begin
      return 8'($urandom_range(8'hFF));
    end
  endfunction

  task automatic queue_text(logic [7:0] b);
    text_queue.push_back(b);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (sent_count != queued_count || escaped_queue.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Sender: a new byte is offered once the previous one has been transferred.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (text_queue.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= text_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off that fills the block up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!stall_done && sent_count >= StallAt) begin
      stall_done   <= 1'b1;
      stall_left   <= StallCycles;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || $urandom_range(99) >= 14;
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer in order.
  always @(posedge clk) begin
    esc_byte_t want;
    cycle_count++;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        escape_run(in_ch.in_byte);
        sent_count <= sent_count + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (escaped_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected output byte %h last %b", $time, out_ch.out_byte,
                   out_ch.run_last);
        end else begin
          want = escaped_queue.pop_front();
          if (want.ch !== out_ch.out_byte || want.last !== out_ch.run_last) begin
            errors++;
            $display("%0t: expected byte %h last %b, actual byte %h last %b", $time,
                     want.ch, want.last, out_ch.out_byte, out_ch.run_last);
          end
        end
      end
    end
    if (cycle_count >= LimitCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero byte, control bytes around the digit boundaries, the passing
    // whitespace, every markup character and both ends of the byte range.
    foreach (MarkupChars[i]) queue_text(MarkupChars[i]);
    queue_text(8'h00);
    queue_text(8'h01);
    queue_text(8'h08);
    queue_text(xte_pkg::ChTab);
    queue_text(xte_pkg::ChLf);
    queue_text(8'h0B);
    queue_text(xte_pkg::ChCr);
    queue_text(8'h13);
    queue_text(8'h14);
    queue_text(8'h1F);
    queue_text(xte_pkg::ChSpace);
    queue_text(8'h21);
    queue_text(xte_pkg::ChHash);
    queue_text(8'h7F);
    queue_text(8'h80);
    queue_text(8'hAA);
    queue_text(8'h55);
    queue_text(8'hFF);
    queue_text(xte_pkg::ChAmp);
    queue_text(xte_pkg::ChAmp);

    repeat (PhaseItems) queue_text(pick_text_byte());
    // The sender stays quiet until the block has delivered everything.
    wait_drained();
    repeat (PhaseItems) queue_text(pick_text_byte());
    wait_drained();
    repeat (DrainCycles) @(negedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
